// File: design/rvm_pkg.sv
// Shared types and constants for the resampling voice mixer.
`timescale 1ns / 1ps
`default_nettype none
package rvm_pkg;
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_FRAME = 2'd3
  } op_e;

  localparam int unsigned STEP_BITS = 21;
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned CUR_BITS  = 33;
  localparam logic [STEP_BITS-1:0] STEP_MIN = 21'd655;
  localparam logic [STEP_BITS-1:0] STEP_MAX = 21'd1048576;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd32768;
endpackage
`default_nettype wire

// File: design/resampling_voice_mixer.sv
// Top level: command decode, voice walk sequencer, interpolation and mix datapath.
// Write, start and stop are taken in their accept cycle; busy does not rise for them.
// A frame walks the voice memory one voice at a time: a silent voice passes S_VRD and
// S_VCHK, a playing one also S_RD0 to S_RD3 (four sample reads through the one read
// port), S_MUL and S_ACC; S_OUT ends the frame and the one-cycle result strobe follows.
// A new frame is taken only once busy has fallen; the receiver cannot stall.
// Reset clears voice state by a pass over the voice memory with busy high.
`timescale 1ns / 1ps
`default_nettype none
module resampling_voice_mixer #(
  parameter int unsigned VOICES           = 16,
  parameter int unsigned SAMPLE_ADDR_BITS = 16,
  parameter int unsigned FRAC_BITS        = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  operation_i,
  input  wire  [3:0]  voice_i,
  input  wire  [15:0] address_i,
  input  wire  signed [15:0] sample_value_i,
  input  wire  [15:0] frame_count_i,
  input  wire         stereo_i,
  input  wire         looping_i,
  input  wire  [20:0] step_i,
  input  wire  [15:0] gain_left_i,
  input  wire  [15:0] gain_right_i,
  output logic        done_o,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [15:0] playing_mask_o
);
  import rvm_pkg::*;

  localparam int unsigned VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned AB = SAMPLE_ADDR_BITS;
  // interpolated sample: 16 + FRAC_BITS + 1 bits; times gain 16 bits; plus voice growth
  localparam int unsigned IB = 17 + FRAC_BITS;
  localparam int unsigned PB = IB + 17;
  localparam int unsigned ACCB = PB + 7;
  localparam int unsigned SH = FRAC_BITS + 15;
  // voice record: cursor, step, base, length, gl, gr, flags(stereo, loop, play)
  localparam int unsigned VW = CUR_BITS + STEP_BITS + 16 + LEN_BITS + 2*GAIN_BITS + 3;

  typedef struct packed {
    logic [CUR_BITS-1:0]  cur;
    logic [STEP_BITS-1:0] stp;
    logic [15:0]          base;
    logic [LEN_BITS-1:0]  len;
    logic [GAIN_BITS-1:0] gl;
    logic [GAIN_BITS-1:0] gr;
    logic                 stereo;
    logic                 loop;
    logic                 play;
  } voice_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VRD, S_VCHK, S_RD0, S_RD1, S_RD2, S_RD3, S_MUL, S_ACC,
    S_OUT
  } state_e;

  state_e state_q;
  logic [VB:0] vidx_q;
  voice_t vcur_q;
  logic [CUR_BITS-1:0] cur_q;
  logic [15:0] w_q [3];
  logic signed [ACCB-1:0] accl_q, accr_q;
  logic signed [IB-1:0] sl_q, sr_q;
  logic signed [PB-1:0] pl_q, pr_q;
  logic [15:0] mask_q;
  logic [1:0] rcnt_q;

  // Voice memory port signals
  logic v_we;
  logic [VB-1:0] v_waddr, v_raddr;
  voice_t v_wdata, v_rdata;

  // Sample memory port signals
  logic s_we;
  logic [AB-1:0] s_raddr;
  logic [15:0] s_rdata;

  logic accept;
  assign accept = start && !busy;

  // Voice index of the command and walk index at full width
  logic [VB-1:0] vsel;
  logic [31:0] vidx_w;
  assign vsel   = VB'(voice_i);
  assign vidx_w = 32'(vidx_q);

  rvm_ram #(.WIDTH(VW), .DEPTH(1 << VB)) u_voice_ram (
    .clk_i(clk_i), .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  rvm_ram #(.WIDTH(16), .DEPTH(1 << AB)) u_sample_ram (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(AB'(address_i)),
    .wdata_i(sample_value_i), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign s_we = accept && (operation_i == OP_WRITE);

  // Clamp start parameters
  logic [STEP_BITS-1:0] stp_c;
  logic [GAIN_BITS-1:0] gl_c, gr_c;
  always_comb begin
    stp_c = (step_i < STEP_MIN) ? STEP_MIN : ((step_i > STEP_MAX) ? STEP_MAX : step_i);
    gl_c  = (gain_left_i > GAIN_ONE) ? GAIN_ONE : gain_left_i;
    gr_c  = (gain_right_i > GAIN_ONE) ? GAIN_ONE : gain_right_i;
  end

  // Voice check: end of sound and loop wrap
  logic [CUR_BITS-1:0] last_sh, cur_w, cur_n;
  logic [CUR_BITS-1:0] idx_a, idx_b, last_w;
  logic chk_stop;
  always_comb begin
    last_w  = CUR_BITS'(v_rdata.len) - CUR_BITS'(1);
    last_sh = last_w << FRAC_BITS;
    idx_a   = v_rdata.cur >> FRAC_BITS;
    cur_w   = v_rdata.cur;
    chk_stop = 1'b0;
    if (v_rdata.len < LEN_BITS'(2)) begin
      chk_stop = 1'b1;
    end else if (idx_a >= last_w) begin
      if (!v_rdata.loop) begin
        chk_stop = 1'b1;
      end else begin
        cur_w = v_rdata.cur - last_sh;
      end
    end
    idx_b = cur_w >> FRAC_BITS;
    cur_n = (idx_b >= last_w && v_rdata.len >= LEN_BITS'(2)) ? '0 : cur_w;
  end

  // Sample address for the current read
  logic [CUR_BITS-1:0] idx_c;
  logic [AB-1:0] a0;
  always_comb begin
    idx_c = cur_q >> FRAC_BITS;
    if (vcur_q.stereo) begin
      a0 = AB'(vcur_q.base) + AB'(idx_c << 1);
      s_raddr = a0 + AB'(rcnt_q);
    end else begin
      a0 = AB'(vcur_q.base) + AB'(idx_c);
      s_raddr = a0 + AB'(rcnt_q[0]);
    end
  end

  // Interpolation weights
  logic [FRAC_BITS:0] frac_w, frac_inv;
  assign frac_w   = {1'b0, cur_q[FRAC_BITS-1:0]};
  assign frac_inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - frac_w;

  // Step in cursor units
  logic [CUR_BITS-1:0] step_cu;
  always_comb begin
    if (FRAC_BITS >= 16) begin
      step_cu = CUR_BITS'(vcur_q.stp) << (FRAC_BITS - 16);
    end else begin
      step_cu = CUR_BITS'(vcur_q.stp) >> (16 - FRAC_BITS);
    end
  end

  // Voice memory access control
  always_comb begin
    v_we    = 1'b0;
    v_waddr = vsel;
    v_wdata = v_rdata;
    v_raddr = vidx_q[VB-1:0];
    unique case (state_q)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = vidx_q[VB-1:0];
        v_wdata = '0;
      end
      S_IDLE: begin
        v_raddr = vsel;
        if (accept && 32'(voice_i) < VOICES) begin
          if (operation_i == OP_START) begin
            v_we = 1'b1;
            v_wdata.cur = '0;
            v_wdata.stp = stp_c;
            v_wdata.base = address_i;
            v_wdata.len = frame_count_i;
            v_wdata.gl = gl_c;
            v_wdata.gr = gr_c;
            v_wdata.stereo = stereo_i;
            v_wdata.loop = looping_i;
            v_wdata.play = 1'b1;
          end else if (operation_i == OP_STOP) begin
            // stop does not write the record: it sets the voice's flag in stopped_q
            v_we = 1'b0;
          end
        end
      end
      S_VCHK: begin
        v_waddr = vidx_q[VB-1:0];
        if (v_rdata.play && chk_stop) begin
          v_we = 1'b1;
          v_wdata.play = 1'b0;
        end
      end
      S_ACC: begin
        v_we = 1'b1;
        v_waddr = vidx_q[VB-1:0];
        v_wdata = vcur_q;
        v_wdata.cur = cur_q + step_cu;
      end
      default: ;
    endcase
  end

  // Stop sets a per-voice flag held separately from the play flag in the record
  logic [VOICES-1:0] stopped_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      vidx_q  <= '0;
      busy    <= 1'b1;
      done_o  <= 1'b0;
      rcnt_q  <= '0;
      mask_q  <= '0;
      stopped_q <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (vidx_q == (VB+1)'(VOICES - 1)) begin
            state_q <= S_IDLE;
            busy    <= 1'b0;
            vidx_q  <= '0;
          end else begin
            vidx_q <= vidx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && 32'(voice_i) < VOICES) begin
            if (operation_i == OP_START) stopped_q[vsel] <= 1'b0;
            if (operation_i == OP_STOP)  stopped_q[vsel] <= 1'b1;
          end
          if (accept && operation_i == OP_FRAME) begin
            state_q <= S_VRD;
            busy    <= 1'b1;
            vidx_q  <= '0;
            mask_q  <= '0;
          end
        end
        S_VRD: state_q <= S_VCHK;
        S_VCHK: begin
          vcur_q <= v_rdata;
          cur_q  <= cur_n;
          rcnt_q <= '0;
          if (v_rdata.play && !stopped_q[vidx_q[VB-1:0]] && !chk_stop) begin
            state_q <= S_RD0;
          end else begin
            if (v_rdata.play && chk_stop) stopped_q[vidx_q[VB-1:0]] <= 1'b1;
            state_q <= (vidx_q == (VB+1)'(VOICES - 1)) ? S_OUT : S_VRD;
            vidx_q  <= vidx_q + 1'b1;
          end
        end
        S_RD0: begin
          rcnt_q <= vcur_q.stereo ? 2'd1 : 2'd1;
          state_q <= S_RD1;
        end
        S_RD1: begin
          w_q[0] <= s_rdata;
          rcnt_q <= 2'd2;
          state_q <= S_RD2;
        end
        S_RD2: begin
          w_q[1] <= s_rdata;
          rcnt_q <= 2'd3;
          state_q <= S_RD3;
        end
        S_RD3: begin
          w_q[2] <= s_rdata;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (vcur_q.stereo) begin
            sl_q <= IB'($signed(w_q[0])) * IB'($signed({1'b0, frac_inv}))
                    + IB'($signed(w_q[2])) * IB'($signed({1'b0, frac_w}));
            sr_q <= IB'($signed(w_q[1])) * IB'($signed({1'b0, frac_inv}))
                    + IB'($signed(s_rdata)) * IB'($signed({1'b0, frac_w}));
          end else begin
            sl_q <= IB'($signed(w_q[0])) * IB'($signed({1'b0, frac_inv}))
                    + IB'($signed(w_q[1])) * IB'($signed({1'b0, frac_w}));
            sr_q <= IB'($signed(w_q[0])) * IB'($signed({1'b0, frac_inv}))
                    + IB'($signed(w_q[1])) * IB'($signed({1'b0, frac_w}));
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (vidx_w < 32'd16) mask_q[vidx_w[3:0]] <= 1'b1;
          state_q <= (vidx_q == (VB+1)'(VOICES - 1)) ? S_OUT : S_VRD;
          vidx_q  <= vidx_q + 1'b1;
        end
        S_OUT: begin
          state_q <= S_IDLE;
          busy    <= 1'b0;
          done_o  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Gain multiply one stage after interpolation, accumulate after
  logic acc_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      pl_q     <= '0;
      pr_q     <= '0;
      accl_q   <= '0;
      accr_q   <= '0;
    end else begin
      acc_en_q <= (state_q == S_ACC);
      if (state_q == S_ACC) begin
        pl_q <= PB'(sl_q) * PB'($signed({1'b0, vcur_q.gl}));
        pr_q <= PB'(sr_q) * PB'($signed({1'b0, vcur_q.gr}));
      end
      if (state_q == S_IDLE) begin
        accl_q <= '0;
        accr_q <= '0;
      end else if (acc_en_q) begin
        accl_q <= accl_q + ACCB'(pl_q);
        accr_q <= accr_q + ACCB'(pr_q);
      end
    end
  end

  // Scale and saturate
  function automatic logic signed [15:0] scale_sat(input logic signed [ACCB-1:0] a);
    logic [ACCB-1:0] m;
    logic signed [ACCB-1:0] r;
    m = a[ACCB-1] ? ACCB'(-a) : ACCB'(a);
    m = m >> SH;
    r = a[ACCB-1] ? -$signed(m) : $signed(m);
    if (r > 32767) return 16'sd32767;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  logic signed [ACCB-1:0] fl, fr;
  assign fl = accl_q + ACCB'(pl_q);
  assign fr = accr_q + ACCB'(pr_q);

  // Output registers, presented with the done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_out_o     <= '0;
      right_out_o    <= '0;
      playing_mask_o <= '0;
    end else if (state_q == S_OUT) begin
      left_out_o     <= scale_sat(acc_en_q ? fl : accl_q);
      right_out_o    <= scale_sat(acc_en_q ? fr : accr_q);
      playing_mask_o <= mask_q;
    end
  end
endmodule
`default_nettype wire

// File: design/rvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rvm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/rvm_checker.sv
// Port-level checker for the resampling voice mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rvm_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire [1:0] operation_i,
  input wire done_o
);
  import rvm_pkg::*;

  // A result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // Results only come while a frame is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("done without frame");

  // A frame command makes the block busy
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_FRAME) |=> busy) else $error("frame not taken");

  // Other commands finish at once
  a_cmd_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i != OP_FRAME) |=> !busy && !done_o)
    else $error("command stalled");
endmodule

bind resampling_voice_mixer rvm_checker u_rvm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .operation_i(operation_i), .done_o(done_o)
);
`default_nettype wire
